>>> rtl/tbop_pkg.sv
// Shared types and codes for the timer bank.
package tbop_pkg;

   typedef enum logic [2:0] {
      ACT_TICK       = 3'd0,
      ACT_CREATE     = 3'd1,
      ACT_REMOVE     = 3'd2,
      ACT_REMOVE_ALL = 3'd3,
      ACT_PAUSE      = 3'd4,
      ACT_RESUME     = 3'd5,
      ACT_RESET      = 3'd6,
      ACT_QUERY      = 3'd7
   } action_type;

   localparam logic KIND_FIRED = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  slot;
      logic [31:0] period;
      logic        periodic;
      logic [31:0] delta;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  which_slot;
      logic        exists;
      logic        done_res;
      logic [31:0] remaining;
      logic        last;
   } rsp_type;

   // Decoded item as it sits in the queue.
   typedef struct packed {
      action_type  op;
      logic        in_range;
      logic [3:0]  slot;
      logic [31:0] period;
      logic        periodic;
      logic [31:0] delta;
   } cmd_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic not_empty;
      logic full;
   } q_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MOD,
      BK_TICK,
      BK_FLUSH
   } bk_state_type;

endpackage

>>> rtl/tbop_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbop_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tbop_front.sv
// Front end: takes items off the request port and decodes them for the queue.
module tbop_front #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                start,
   input  tbop_pkg::req_type   req_data,
   input  tbop_pkg::q_stat_type q_stat,
   output logic                busy,
   output logic                push,
   output tbop_pkg::cmd_type   push_cmd
);

   always_comb begin
      busy              = q_stat.full;
      push              = start && !q_stat.full;
      push_cmd.op       = tbop_pkg::action_type'(req_data.action);
      // slots past the bank size behave as absent
      push_cmd.in_range = ({28'd0, req_data.slot} < 32'(NUM_SLOTS));
      push_cmd.slot     = req_data.slot;
      push_cmd.period   = req_data.period;
      push_cmd.periodic = req_data.periodic;
      push_cmd.delta    = req_data.delta;
   end

endmodule

>>> rtl/tbop_fifo.sv
// Two-entry queue of decoded items between front and back end.
module tbop_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tbop_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output tbop_pkg::cmd_type    head,
   output tbop_pkg::q_stat_type q_stat
);

   tbop_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      head      = entry_ff[rd_ptr_ff];
      q_stat.not_empty = (count_ff != 2'd0);
      q_stat.full      = (count_ff == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/tbop_back.sv
// Back end: executes queued items against the slot store and drives results.
module tbop_back #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tbop_pkg::cmd_type    head,
   input  tbop_pkg::q_stat_type q_stat,
   output logic                 pop,
   output logic                 rsp_valid,
   output tbop_pkg::rsp_type    rsp_data
);

   localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int IN_W       = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam int WORD_W     = 2 * TIME_BITS + 3;
   localparam int DONE_B     = 0;
   localparam int PAUSED_B   = 1;
   localparam int PERIODIC_B = 2;
   localparam int ELAPSED_LO = 3;
   localparam int PERIOD_LO  = 3 + TIME_BITS;
   localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [TIME_BITS-1:0] TMAX     = {TIME_BITS{1'b1}};

   // word layout: {period, elapsed, periodic, paused, done}
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [WORD_W-1:0]    ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [WORD_W-1:0]    ram_rdata;

   tbop_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tbop_pkg::bk_state_type state_ff, state_in;
   tbop_pkg::cmd_type      cur_ff, cur_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   issue_ff, issue_in;
   logic                   p1_go_ff, p1_go_in;
   logic                   p1_last_ff, p1_last_in;
   logic [IDX_W-1:0]       p1_idx_ff, p1_idx_in;
   logic                   s2_go_ff, s2_go_in;
   logic                   s2_last_ff, s2_last_in;
   logic                   s2_run_ff, s2_run_in;
   logic [IDX_W-1:0]       s2_idx_ff, s2_idx_in;
   logic [TIME_BITS-1:0]   s2_sum_ff, s2_sum_in;
   logic [WORD_W-1:0]      s2_word_ff, s2_word_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic [IDX_W-1:0]       hold_idx_ff, hold_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tbop_pkg::rsp_type      rsp_ff, rsp_in;

   logic [IDX_W-1:0]       hidx, cidx;
   logic                   here;
   logic [TIME_BITS-1:0]   new_period, tick_delta;
   logic [TIME_BITS:0]     add_full, sub_full, rem_full;
   logic [TIME_BITS-1:0]   sat_sum, s2_period, rem_val;
   logic                   fire;
   logic [WORD_W-1:0]      word_mod;

   always_comb begin
      hidx       = IDX_W'(head.slot);
      cidx       = IDX_W'(cur_ff.slot);
      here       = head.in_range && valid_ff[hidx];
      new_period = TIME_BITS'(head.period[IN_W-1:0]);
      tick_delta = TIME_BITS'(cur_ff.delta[IN_W-1:0]);

      // stage 1: saturating add of the tick delta
      add_full = {1'b0, ram_rdata[ELAPSED_LO +: TIME_BITS]} + {1'b0, tick_delta};
      sat_sum  = add_full[TIME_BITS] ? TMAX : add_full[TIME_BITS-1:0];

      // stage 2: compare against period via the borrow of one subtract
      s2_period = s2_word_ff[PERIOD_LO +: TIME_BITS];
      sub_full  = {1'b0, s2_sum_ff} - {1'b0, s2_period};
      fire      = !sub_full[TIME_BITS];

      rem_full = {1'b0, ram_rdata[PERIOD_LO +: TIME_BITS]}
               - {1'b0, ram_rdata[ELAPSED_LO +: TIME_BITS]};
      rem_val  = rem_full[TIME_BITS] ? '0 : rem_full[TIME_BITS-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      rd_idx_in    = rd_idx_ff;
      issue_in     = issue_ff;
      p1_go_in     = 1'b0;
      p1_last_in   = 1'b0;
      p1_idx_in    = rd_idx_ff;
      s2_go_in     = p1_go_ff;
      s2_last_in   = p1_last_ff;
      s2_idx_in    = p1_idx_ff;
      s2_run_in    = p1_go_ff && valid_ff[p1_idx_ff] && !ram_rdata[PAUSED_B]
                     && !ram_rdata[DONE_B];
      s2_sum_in    = sat_sum;
      s2_word_in   = ram_rdata;
      hold_vld_in  = hold_vld_ff;
      hold_idx_in  = hold_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = hidx;
      ram_wdata    = {new_period, {TIME_BITS{1'b0}}, head.periodic, 1'b0, 1'b0};
      ram_raddr    = hidx;
      word_mod     = ram_rdata;

      unique case (state_ff)
         tbop_pkg::BK_IDLE: begin
            if (q_stat.not_empty) begin
               pop    = 1'b1;
               cur_in = head;
               unique case (head.op) inside
                  tbop_pkg::ACT_TICK: begin
                     issue_in    = 1'b1;
                     rd_idx_in   = '0;
                     hold_vld_in = 1'b0;
                     state_in    = tbop_pkg::BK_TICK;
                  end
                  tbop_pkg::ACT_CREATE: begin
                     if (head.in_range) begin
                        ram_we         = 1'b1;
                        valid_in[hidx] = 1'b1;
                     end
                  end
                  tbop_pkg::ACT_REMOVE: begin
                     if (here) begin
                        valid_in[hidx] = 1'b0;
                     end
                  end
                  tbop_pkg::ACT_REMOVE_ALL: begin
                     valid_in = '0;
                  end
                  tbop_pkg::ACT_PAUSE, tbop_pkg::ACT_RESUME, tbop_pkg::ACT_RESET: begin
                     if (here) begin
                        state_in = tbop_pkg::BK_MOD;
                     end
                  end
                  tbop_pkg::ACT_QUERY: begin
                     if (here) begin
                        state_in = tbop_pkg::BK_MOD;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.kind       = tbop_pkg::KIND_QUERY;
                        rsp_in.which_slot = head.slot;
                        rsp_in.exists     = 1'b0;
                        rsp_in.done_res   = 1'b1;
                        rsp_in.remaining  = '0;
                        rsp_in.last       = 1'b1;
                     end
                  end
               endcase
            end
         end

         tbop_pkg::BK_MOD: begin
            // slot word was read the cycle before
            ram_waddr = cidx;
            state_in  = tbop_pkg::BK_IDLE;
            unique case (cur_ff.op)
               tbop_pkg::ACT_PAUSE: begin
                  word_mod[PAUSED_B] = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = word_mod;
               end
               tbop_pkg::ACT_RESUME: begin
                  word_mod[PAUSED_B] = 1'b0;
                  ram_we    = 1'b1;
                  ram_wdata = word_mod;
               end
               tbop_pkg::ACT_RESET: begin
                  word_mod[ELAPSED_LO +: TIME_BITS] = '0;
                  word_mod[DONE_B] = 1'b0;
                  ram_we    = 1'b1;
                  ram_wdata = word_mod;
               end
               tbop_pkg::ACT_QUERY: begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.kind       = tbop_pkg::KIND_QUERY;
                  rsp_in.which_slot = cur_ff.slot;
                  rsp_in.exists     = 1'b1;
                  rsp_in.done_res   = ram_rdata[DONE_B];
                  rsp_in.remaining  = 32'(rem_val);
                  rsp_in.last       = 1'b1;
               end
               default: begin
               end
            endcase
         end

         tbop_pkg::BK_TICK: begin
            if (issue_ff) begin
               ram_raddr  = rd_idx_ff;
               p1_go_in   = 1'b1;
               p1_last_in = (rd_idx_ff == LAST_IDX);
               if (rd_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (s2_go_ff && s2_run_ff) begin
               ram_we    = 1'b1;
               ram_waddr = s2_idx_ff;
               ram_wdata = s2_word_ff;
               ram_wdata[ELAPSED_LO +: TIME_BITS] =
                  (fire && s2_word_ff[PERIODIC_B]) ? sub_full[TIME_BITS-1:0] : s2_sum_ff;
               if (fire && !s2_word_ff[PERIODIC_B]) begin
                  ram_wdata[DONE_B] = 1'b1;
               end
               // a fired slot is held back until the next one fires or the walk ends, so the last one can be marked
               if (fire) begin
                  if (hold_vld_ff) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.kind       = tbop_pkg::KIND_FIRED;
                     rsp_in.which_slot = 4'(hold_idx_ff);
                     rsp_in.exists     = 1'b0;
                     rsp_in.done_res   = 1'b0;
                     rsp_in.remaining  = '0;
                     rsp_in.last       = 1'b0;
                  end
                  hold_vld_in = 1'b1;
                  hold_idx_in = s2_idx_ff;
               end
            end
            if (s2_go_ff && s2_last_ff) begin
               state_in = tbop_pkg::BK_FLUSH;
            end
         end

         tbop_pkg::BK_FLUSH: begin
            if (hold_vld_ff) begin
               rsp_valid_in      = 1'b1;
               rsp_in.kind       = tbop_pkg::KIND_FIRED;
               rsp_in.which_slot = 4'(hold_idx_ff);
               rsp_in.exists     = 1'b0;
               rsp_in.done_res   = 1'b0;
               rsp_in.remaining  = '0;
               rsp_in.last       = 1'b1;
            end
            hold_vld_in = 1'b0;
            state_in    = tbop_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbop_pkg::BK_IDLE;
         valid_ff     <= '0;
         issue_ff     <= 1'b0;
         p1_go_ff     <= 1'b0;
         s2_go_ff     <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         issue_ff     <= issue_in;
         p1_go_ff     <= p1_go_in;
         s2_go_ff     <= s2_go_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rd_idx_ff   <= rd_idx_in;
      p1_last_ff  <= p1_last_in;
      p1_idx_ff   <= p1_idx_in;
      s2_last_ff  <= s2_last_in;
      s2_run_ff   <= s2_run_in;
      s2_idx_ff   <= s2_idx_in;
      s2_sum_ff   <= s2_sum_in;
      s2_word_ff  <= s2_word_in;
      hold_idx_ff <= hold_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/timer_bank_one_shot_periodic_core.sv
// Timer bank top level: front end, item queue and back end.
//
// Usage: drive req_data and raise start; the item is taken at a clock edge
// where start is high and busy is low. Results come out on rsp_data, each
// marked by rsp_valid for one cycle; the receiver must take every one.
// A two-entry queue sits between the decoder and the executing back end, so
// busy rises only when two items are waiting.
// After acceptance, create, remove, remove-all and an absent query are done
// in the back end's idle state, an absent query's answer being registered;
// pause, resume, reset and a present query also pass through a modify state,
// which uses the registered read of the slot store.
// A tick walks the slot store one slot per cycle through a two-stage
// add/compare pipeline. Fired results come out in slot order; each is held
// until the next slot fires or the walk ends, so the final one carries last.
// Reset empties the queue and marks every slot absent; no clearing pass.
module timer_bank_one_shot_periodic_core #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tbop_pkg::req_type req_data,
   output logic              rsp_valid,
   output tbop_pkg::rsp_type rsp_data
);

   tbop_pkg::q_stat_type q_stat;
   tbop_pkg::cmd_type    push_cmd;
   tbop_pkg::cmd_type    head;
   logic                 push;
   logic                 pop;

   tbop_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .start    (start),
      .req_data (req_data),
      .q_stat   (q_stat),
      .busy     (busy),
      .push     (push),
      .push_cmd (push_cmd)
   );

   tbop_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   tbop_back #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_query_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == tbop_pkg::KIND_QUERY) |-> rsp_data.last)
      else $error("query answer without last");

   a_fired_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == tbop_pkg::KIND_FIRED)
         |-> (!rsp_data.exists && !rsp_data.done_res && rsp_data.remaining == 32'd0))
      else $error("fired item carries query fields");

   a_reset_not_busy: assert property (@(posedge clock)
      reset |=> !busy)
      else $error("busy right after reset");

endmodule

>>> tb/timer_bank_one_shot_periodic_core_tb.sv
// Self-checking testbench for the timer bank: directed corner cases, full-bank ticks, random mix.
module timer_bank_one_shot_periodic_core_tb;

   localparam int NUM_SLOTS     = 16;
   localparam int TIME_BITS     = 32;
   localparam int STUCK_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 8;
   localparam int MAX_PRINTS    = 40;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   tbop_pkg::req_type req_data;
   logic              rsp_valid;
   tbop_pkg::rsp_type rsp_data;

   // shadow copy of the slot store
   bit        bank_valid    [NUM_SLOTS];
   bit [31:0] bank_period   [NUM_SLOTS];
   bit [31:0] bank_elapsed  [NUM_SLOTS];
   bit        bank_periodic [NUM_SLOTS];
   bit        bank_paused   [NUM_SLOTS];
   bit        bank_done     [NUM_SLOTS];

   tbop_pkg::rsp_type expected_results[$];
   int                error_count;
   int                burst_left;
   int                stuck_cycles;

   timer_bank_one_shot_periodic_core #(
      .NUM_SLOTS(NUM_SLOTS),
      .TIME_BITS(TIME_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTS)
         $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Advance the shadow bank by one accepted item and queue the results it causes.
   task automatic predict_item(tbop_pkg::req_type item);
      tbop_pkg::action_type op;
      tbop_pkg::rsp_type    res;
      tbop_pkg::rsp_type    fired[$];
      bit [32:0]            sum;
      int                   s;
      op = tbop_pkg::action_type'(item.action);
      s  = item.slot;
      case (op)
         tbop_pkg::ACT_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (bank_valid[i] && !bank_paused[i] && !bank_done[i]) begin
                  sum = {1'b0, bank_elapsed[i]} + {1'b0, item.delta};
                  bank_elapsed[i] = sum[32] ? '1 : sum[31:0];
                  if (bank_elapsed[i] >= bank_period[i]) begin
                     if (bank_periodic[i])
                        bank_elapsed[i] = bank_elapsed[i] - bank_period[i];
                     else
                        bank_done[i] = 1'b1;
                     res            = '0;
                     res.kind       = tbop_pkg::KIND_FIRED;
                     res.which_slot = 4'(i);
                     fired          = {fired, res};
                  end
               end
            end
            if (fired.size() > 0)
               fired[fired.size() - 1].last = 1'b1;
            foreach (fired[k])
               expected_results = {expected_results, fired[k]};
         end
         tbop_pkg::ACT_CREATE: begin
            bank_valid[s]    = 1'b1;
            bank_period[s]   = item.period;
            bank_elapsed[s]  = '0;
            bank_periodic[s] = item.periodic;
            bank_paused[s]   = 1'b0;
            bank_done[s]     = 1'b0;
         end
         tbop_pkg::ACT_REMOVE: bank_valid[s] = 1'b0;
         tbop_pkg::ACT_REMOVE_ALL: begin
            foreach (bank_valid[i])
               bank_valid[i] = 1'b0;
         end
         tbop_pkg::ACT_PAUSE: begin
            if (bank_valid[s])
               bank_paused[s] = 1'b1;
         end
         tbop_pkg::ACT_RESUME: begin
            if (bank_valid[s])
               bank_paused[s] = 1'b0;
         end
         tbop_pkg::ACT_RESET: begin
            if (bank_valid[s]) begin
               bank_elapsed[s] = '0;
               bank_done[s]    = 1'b0;
            end
         end
         tbop_pkg::ACT_QUERY: begin
            res            = '0;
            res.kind       = tbop_pkg::KIND_QUERY;
            res.which_slot = item.slot;
            res.last       = 1'b1;
            if (bank_valid[s]) begin
               res.exists    = 1'b1;
               res.done_res  = bank_done[s];
               res.remaining = (bank_period[s] > bank_elapsed[s]) ?
                               bank_period[s] - bank_elapsed[s] : '0;
            end else begin
               res.done_res = 1'b1;
            end
            expected_results = {expected_results, res};
         end
      endcase
   endtask

   // Results cannot be held off, so every strobed cycle is checked.
   always @(posedge clock) begin
      tbop_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0h slot %0d",
                                         rsp_data.kind, rsp_data.which_slot));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.kind !== want.kind)
                  report_mismatch($sformatf("kind got %0h want %0h",
                                            rsp_data.kind, want.kind));
               if (rsp_data.which_slot !== want.which_slot)
                  report_mismatch($sformatf("which_slot got %0d want %0d",
                                            rsp_data.which_slot, want.which_slot));
               if (rsp_data.exists !== want.exists)
                  report_mismatch($sformatf("exists got %0h want %0h slot %0d",
                                            rsp_data.exists, want.exists, want.which_slot));
               if (rsp_data.done_res !== want.done_res)
                  report_mismatch($sformatf("done_res got %0h want %0h slot %0d",
                                            rsp_data.done_res, want.done_res,
                                            want.which_slot));
               if (rsp_data.remaining !== want.remaining)
                  report_mismatch($sformatf("remaining got %0h want %0h slot %0d",
                                            rsp_data.remaining, want.remaining,
                                            want.which_slot));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last got %0h want %0h slot %0d",
                                            rsp_data.last, want.last, want.which_slot));
            end
         end
         if (start && !busy)
            predict_item(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timer_bank_one_shot_periodic_core verification failed");
         $finish;
      end
   end

   function automatic tbop_pkg::req_type make_item(tbop_pkg::action_type op, int slot,
                                                   bit [31:0] period, bit periodic,
                                                   bit [31:0] delta);
      tbop_pkg::req_type item;
      item.action   = op;
      item.slot     = 4'(slot);
      item.period   = period;
      item.periodic = periodic;
      item.delta    = delta;
      return item;
   endfunction

   // Sender works in bursts; start stays high across back-to-back items.
   task automatic send_item(tbop_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            7:       gap = $urandom_range(9, 25);
            default: gap = $urandom_range(1, 8);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      // a tick that fires nothing may still be walking the bank
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_zero_and_saturation();
      send_item(make_item(tbop_pkg::ACT_QUERY, 0, 0, 0, 0));          // never created
      send_item(make_item(tbop_pkg::ACT_CREATE, 0, 0, 1'b1, 0));
      send_item(make_item(tbop_pkg::ACT_CREATE, 15, 0, 1'b0, 0));
      send_item(make_item(tbop_pkg::ACT_CREATE, 1, '1, 1'b1, 0));
      send_item(make_item(tbop_pkg::ACT_CREATE, 2, 100, 1'b0, 0));
      send_item(make_item(tbop_pkg::ACT_TICK, 0, 0, 0, 0));           // zero periods fire
      send_item(make_item(tbop_pkg::ACT_TICK, 9, 0, 0, 10));
      send_item(make_item(tbop_pkg::ACT_TICK, 0, 0, 0, '1));          // elapsed saturates
      send_item(make_item(tbop_pkg::ACT_QUERY, 2, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_QUERY, 15, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_CREATE, 4, 100, 1'b1, 0));
      send_item(make_item(tbop_pkg::ACT_TICK, 0, 0, 0, 250));         // overshoot kept once
      send_item(make_item(tbop_pkg::ACT_QUERY, 4, 0, 0, 0));          // remaining clamps at zero
   endtask

   task automatic test_pause_reset_absent();
      send_item(make_item(tbop_pkg::ACT_PAUSE, 0, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_TICK, 0, 0, 0, 1));
      send_item(make_item(tbop_pkg::ACT_QUERY, 0, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_RESUME, 0, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_RESET, 15, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_QUERY, 15, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_REMOVE, 2, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_PAUSE, 2, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_RESUME, 2, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_RESET, 2, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_REMOVE, 2, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_QUERY, 2, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_REMOVE_ALL, 0, 0, 0, 0));
      send_item(make_item(tbop_pkg::ACT_TICK, 0, 0, 0, 5));           // nothing left to fire
      send_item(make_item(tbop_pkg::ACT_QUERY, 4, 0, 0, 0));
   endtask

   // Every slot fires on every tick: the longest result trains.
   task automatic test_full_bank();
      for (int i = 0; i < NUM_SLOTS; i++)
         send_item(make_item(tbop_pkg::ACT_CREATE, i, $urandom_range(0, 2), 1'b1, 0));
      repeat (4)
         send_item(make_item(tbop_pkg::ACT_TICK, 0, 0, 0, $urandom_range(2, 9)));
      send_item(make_item(tbop_pkg::ACT_REMOVE_ALL, 0, 0, 0, 0));
   endtask

   task automatic test_random_mix(int count);
      tbop_pkg::req_type item;
      int                pick;
      repeat (count) begin
         item.slot     = 4'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 5) :
                                                          $urandom_range(0, 15));
         item.period   = $urandom();
         item.periodic = 1'($urandom_range(0, 1));
         item.delta    = $urandom();
         pick          = $urandom_range(0, 99);
         if (pick < 25) begin
            item.action = tbop_pkg::ACT_CREATE;
            case ($urandom_range(0, 9))
               0:       item.period = '0;
               1:       ;
               default: item.period = $urandom_range(0, 400);
            endcase
         end else if (pick < 55) begin
            item.action = tbop_pkg::ACT_TICK;
            case ($urandom_range(0, 9))
               0:       item.delta = '0;
               1:       ;
               default: item.delta = $urandom_range(0, 300);
            endcase
         end else if (pick < 70) item.action = tbop_pkg::ACT_QUERY;
         else if (pick < 78)     item.action = tbop_pkg::ACT_PAUSE;
         else if (pick < 86)     item.action = tbop_pkg::ACT_RESUME;
         else if (pick < 92)     item.action = tbop_pkg::ACT_RESET;
         else if (pick < 98)     item.action = tbop_pkg::ACT_REMOVE;
         else                    item.action = tbop_pkg::ACT_REMOVE_ALL;
         send_item(item);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      error_count = 0;
      burst_left  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_and_saturation();
      wait_drain();
      test_pause_reset_absent();
      wait_drain();
      test_full_bank();
      wait_drain();
      test_random_mix(100);
      wait_drain();

      if (error_count == 0)
         $display("timer_bank_one_shot_periodic_core verification clean");
      else
         $display("timer_bank_one_shot_periodic_core verification failed");
      $finish;
   end

endmodule
